// ----- hdl/dda_line_char_plotter_unit_macros.svh -----
// Assertion macros shared by the line plotter modules.
`ifndef DDA_LINE_CHAR_PLOTTER_UNIT_MACROS_SVH
`define DDA_LINE_CHAR_PLOTTER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define DLCP_ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define DLCP_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hdl/dlcp_pkg.sv -----
// Package: widths, register indexes, controller states and control structs.
`timescale 1ns / 1ps
package dlcp_pkg;

  localparam int MAX_SCREEN = 64;
  localparam int FRAC_BITS  = 16;

  // Field and register widths
  localparam int CRD_W  = 6;
  localparam int DLT_W  = CRD_W + 1;
  localparam int MAG_W  = CRD_W;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 2;
  localparam int ADDR_W = 13;
  localparam int SCR_W  = 6;

  // Divider and position widths
  localparam int DIV_W  = MAG_W + FRAC_BITS + 1;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int OFS_W  = FRAC_BITS + MAG_W;
  localparam int POS_W  = FRAC_BITS + 8;
  localparam int REM_W  = DLT_W + 1;
  localparam int CNT_W  = $clog2(DIV_W);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic div_en;
    logic gen_en;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic at_last;
    logic adv;
  } status_t;

endpackage

// ----- hdl/dda_line_char_plotter_unit.sv -----
// DDA line plotter for a character screen: top level.
//
// Input channel (in_valid / in_stall) takes one line per item: start_x,
// start_y, end_x, end_y, signed, centre origin, y up. Output channel
// (out_valid / out_stall) gives one item per step of the line: pixel_address
// (row*(width+1)+column, 0 when outside), pixel_inside, run_last.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
// screen_width (saturated to 1..64), index 1 is screen_height (2..64);
// other indexes are ignored. Write only while no line is in flight.
// Timing: a line of m+1 steps (m = larger absolute delta) holds off the input
// while it runs: an accept, then the bit-serial step divider (FRAC_BITS+7
// bits), then one step per cycle while the output is not stalled. The first
// result passes through the stage register and then the output register.
// A stall on the output freezes the step pipeline; no result is dropped.
// Reset (rst, synchronous) restores 64x64, empties the pipeline; the input
// and config channels are held off while rst is high.
`timescale 1ns / 1ps
module dda_line_char_plotter_unit
  import dlcp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CRD_W-1:0]  start_x,
  input  logic signed [CRD_W-1:0]  start_y,
  input  logic signed [CRD_W-1:0]  end_x,
  input  logic signed [CRD_W-1:0]  end_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ADDR_W-1:0]        pixel_address,
  output logic                     pixel_inside,
  output logic                     run_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  cmd_t    cmd;
  status_t st;

  // Sequencer
  dlcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Arithmetic and output stages
  dlcp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_address (pixel_address),
    .pixel_inside  (pixel_inside),
    .run_last      (run_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule

// ----- hdl/dlcp_ctrl.sv -----
// Controller: sequences line setup, the divide and the step run.
`timescale 1ns / 1ps
`include "dda_line_char_plotter_unit_macros.svh"
module dlcp_ctrl
  import dlcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !rst) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (st.div_done) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (st.adv && st.at_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.div_en = 1'b0;
    cmd.gen_en = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
      end
      ST_RUN: begin
        cmd.gen_en = st.adv;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  `DLCP_ASSERT_NEXT(a_div_to_run, (state == ST_DIV) && st.div_done, state == ST_RUN, "divide did not hand over to run")
  `DLCP_ASSERT_NEXT(a_last_to_idle, cmd.gen_en && st.at_last, state == ST_IDLE && !in_stall, "block not free after last step")

endmodule

// ----- hdl/dlcp_datapath.sv -----
// Datapath: config registers, step divider, DDA accumulators, output stages.
`timescale 1ns / 1ps
`include "dda_line_char_plotter_unit_macros.svh"
module dlcp_datapath
  import dlcp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  st,
  input  logic signed [CRD_W-1:0]  start_x,
  input  logic signed [CRD_W-1:0]  start_y,
  input  logic signed [CRD_W-1:0]  end_x,
  input  logic signed [CRD_W-1:0]  end_y,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic [ADDR_W-1:0]        pixel_address,
  output logic                     pixel_inside,
  output logic                     run_last,
  output logic                     out_valid,
  input  logic                     out_stall
);

  localparam logic signed [POS_W-1:0] NEG_ONE =
    {{(POS_W-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

  // Configuration
  logic [CFG_W-1:0] screen_width, screen_height;
  logic             cfg_we;

  // Line setup
  logic [MAG_W-1:0]        m;
  logic [DLT_W-1:0]        div2m;
  logic                    neg_x, neg_y;
  logic signed [POS_W-1:0] base_x, base_y;

  // Divider lanes
  logic [CNT_W-1:0] div_cnt;
  logic [DIV_W-1:0] dv_x, dv_y;
  logic [REM_W-1:0] dr_x, dr_y;

  // Accumulators
  logic [OFS_W-1:0] acc_qx, acc_qy;
  logic [REM_W-1:0] acc_rx, acc_ry;
  logic [MAG_W-1:0] step_i;

  // Stage and output registers
  logic             s_valid, s_inside, s_last;
  logic [SCR_W-1:0] s_col, s_row;

  // Combinational
  logic signed [DLT_W-1:0] dx, dy;
  logic [MAG_W-1:0]        abs_x, abs_y, m_new;
  logic signed [POS_W-1:0] half_w, half_h, x0_fix, y0_fix;
  logic [REM_W-1:0]        sh_x, sh_y, rs_x, rs_y;
  logic                    bit_x, bit_y, wrap_x, wrap_y;
  logic signed [POS_W-1:0] off_x, off_y, vx, vy;
  logic signed [7:0]       ip_x, ip_y;
  logic                    in_x, in_y;
  logic [SCR_W-1:0]        col, row;
  logic [ADDR_W-1:0]       addr;
  logic                    adv;

  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign adv       = !out_valid || !out_stall;

  assign st.div_done = (div_cnt == CNT_W'(DIV_W - 1));
  assign st.at_last  = (step_i == m);
  assign st.adv      = adv;

  // Configuration write with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= CFG_W'(MAX_SCREEN);
      screen_height <= CFG_W'(MAX_SCREEN);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH: begin
          if (cfg_data < CFG_W'(1)) screen_width <= CFG_W'(1);
          else if (cfg_data > CFG_W'(MAX_SCREEN)) screen_width <= CFG_W'(MAX_SCREEN);
          else screen_width <= cfg_data;
        end
        REG_SCREEN_HEIGHT: begin
          if (cfg_data < CFG_W'(2)) screen_height <= CFG_W'(2);
          else if (cfg_data > CFG_W'(MAX_SCREEN)) screen_height <= CFG_W'(MAX_SCREEN);
          else screen_height <= cfg_data;
        end
        default: ;
      endcase
    end
  end

  // Line setup terms
  always_comb begin
    dx     = DLT_W'(end_x) - DLT_W'(start_x);
    dy     = DLT_W'(end_y) - DLT_W'(start_y);
    abs_x  = dx[DLT_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    abs_y  = dy[DLT_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    m_new  = (abs_x > abs_y) ? abs_x : abs_y;
    half_w = $signed(POS_W'({screen_width, {(FRAC_BITS-1){1'b0}}}));
    half_h = $signed(POS_W'({screen_height, {(FRAC_BITS-1){1'b0}}}));
    x0_fix = POS_W'(start_x) <<< FRAC_BITS;
    y0_fix = POS_W'(start_y) <<< FRAC_BITS;
  end

  // Restoring divide step, one quotient bit per lane per cycle
  always_comb begin
    sh_x  = {dr_x[REM_W-2:0], dv_x[DIV_W-1]};
    sh_y  = {dr_y[REM_W-2:0], dv_y[DIV_W-1]};
    bit_x = (sh_x >= {1'b0, div2m});
    bit_y = (sh_y >= {1'b0, div2m});
  end

  // Per-step remainder carry
  always_comb begin
    rs_x   = acc_rx + {1'b0, dr_x[REM_W-2:0]};
    rs_y   = acc_ry + {1'b0, dr_y[REM_W-2:0]};
    wrap_x = (rs_x >= {1'b0, div2m});
    wrap_y = (rs_y >= {1'b0, div2m});
  end

  // Setup, divider and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      m      <= '0;
      div2m  <= '0;
      acc_rx <= '0;
      acc_ry <= '0
      ;
    end else if (cmd.load) begin
      m       <= m_new;
      div2m   <= {m_new, 1'b0};
      neg_x   <= dx[DLT_W-1];
      neg_y   <= dy[DLT_W-1];
      base_x  <= x0_fix + half_w;
      base_y  <= half_h - y0_fix;
      div_cnt <= '0;
      dv_x    <= {abs_x, {(FRAC_BITS+1){1'b0}}};
      dv_y    <= {abs_y, {(FRAC_BITS+1){1'b0}}};
      dr_x    <= '0;
      dr_y    <= '0;
      acc_qx  <= '0;
      acc_qy  <= '0;
      acc_rx  <= REM_W'(m_new);
      acc_ry  <= REM_W'(m_new);
      step_i  <= '0;
    end else if (cmd.div_en) begin
      div_cnt <= div_cnt + CNT_W'(1);
      dv_x    <= {dv_x[DIV_W-2:0], bit_x};
      dv_y    <= {dv_y[DIV_W-2:0], bit_y};
      dr_x    <= bit_x ? sh_x - {1'b0, div2m} : sh_x;
      dr_y    <= bit_y ? sh_y - {1'b0, div2m} : sh_y;
    end else if (cmd.gen_en && !st.at_last) begin
      step_i <= step_i + MAG_W'(1);
      acc_qx <= acc_qx + OFS_W'(dv_x[QUO_W-1:0]) + OFS_W'(wrap_x);
      acc_qy <= acc_qy + OFS_W'(dv_y[QUO_W-1:0]) + OFS_W'(wrap_y);
      acc_rx <= wrap_x ? rs_x - {1'b0, div2m} : rs_x;
      acc_ry <= wrap_y ? rs_y - {1'b0, div2m} : rs_y;
    end
  end

  // Screen position of the current step, truncated toward zero
  always_comb begin
    off_x = $signed(POS_W'(acc_qx));
    off_y = $signed(POS_W'(acc_qy));
    vx    = neg_x ? base_x - off_x : base_x + off_x;
    vy    = neg_y ? base_y + off_y : base_y - off_y;
    ip_x  = vx[POS_W-1:FRAC_BITS];
    ip_y  = vy[POS_W-1:FRAC_BITS];
    in_x  = (vx > NEG_ONE) && (ip_x < $signed({1'b0, screen_width}));
    in_y  = (vy > NEG_ONE) && (ip_y < $signed({1'b0, screen_height - CFG_W'(1)}));
    col   = vx[POS_W-1] ? '0 : vx[FRAC_BITS+SCR_W-1:FRAC_BITS];
    row   = vy[POS_W-1] ? '0 : vy[FRAC_BITS+SCR_W-1:FRAC_BITS];
  end

  // Buffer address from the staged step
  assign addr = s_inside
    ? ADDR_W'(ADDR_W'(s_row) * ADDR_W'(screen_width + CFG_W'(1)) + ADDR_W'(s_col))
    : '0;

  // Two-deep output pipeline, moves when the output slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s_valid   <= cmd.gen_en;
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_col         <= col;
      s_row         <= row;
      s_inside      <= in_x && in_y;
      s_last        <= st.at_last;
      pixel_address <= addr;
      pixel_inside  <= s_inside;
      run_last      <= s_last;
    end
  end

  `DLCP_ASSERT_IMPLY(a_rem_bound, div2m != '0, (acc_rx < {1'b0, div2m}) && (acc_ry < {1'b0, div2m}), "step remainder out of range")
  `DLCP_ASSERT_IMPLY(a_outside_zero, out_valid && !pixel_inside, pixel_address == '0, "address set for an outside step")
  `DLCP_ASSERT_NEXT(a_last_moves, s_valid && s_last && adv, out_valid && run_last, "last step lost on its way out")

endmodule

// ----- tb/dda_line_char_plotter_checker.sv -----
`timescale 1ns / 1ps
// Checker for the line plotter: tracks screen registers, predicts every pixel step, compares.
module dda_line_char_plotter_checker
  import dlcp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [CRD_W-1:0] start_x,
  input  logic signed [CRD_W-1:0] start_y,
  input  logic signed [CRD_W-1:0] end_x,
  input  logic signed [CRD_W-1:0] end_y,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [ADDR_W-1:0]       pixel_address,
  input  logic                    pixel_inside,
  input  logic                    run_last,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output int                      fail_count,
  output int                      pending_steps
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              on_screen;
    logic              last;
  } pixel_step_t;

  pixel_step_t       expected_pixels[$];
  logic [CFG_W-1:0]  cols = CFG_W'(MAX_SCREEN);
  logic [CFG_W-1:0]  rows = CFG_W'(MAX_SCREEN);

  initial fail_count = 0;
  initial pending_steps = 0;

  function automatic logic [CFG_W-1:0] clamp_cfg(logic [CFG_W-1:0] v, int lo);
    if (v < CFG_W'(lo)) return CFG_W'(lo);
    if (v > CFG_W'(MAX_SCREEN)) return CFG_W'(MAX_SCREEN);
    return v;
  endfunction

  // delta*i/m in fixed point, rounded half away from zero
  function automatic longint step_offset(longint d, longint i, longint m);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = (mag * i * (longint'(1) << (FRAC_BITS + 1)) + m) / (2 * m);
    return (d < 0) ? -q : q;
  endfunction

  // integer part, truncated toward zero
  function automatic longint whole_part(longint v);
    if (v >= 0) return v >>> FRAC_BITS;
    return -((-v) >>> FRAC_BITS);
  endfunction

  // queue one expected pixel per DDA step of the line
  function automatic void plot_line(longint x0, longint y0, longint x1, longint y1);
    longint one;
    longint dx, dy, ax, ay, m, w, h;
    longint px, py, col, row, i;
    pixel_step_t p;
    one = longint'(1) << FRAC_BITS;
    dx = x1 - x0;
    dy = y1 - y0;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    m = (ax > ay) ? ax : ay;
    w = longint'(cols);
    h = longint'(rows);
    for (i = 0; i <= m; i++) begin
      px = x0 * one;
      py = y0 * one;
      if (m > 0) begin
        px += step_offset(dx, i, m);
        py += step_offset(dy, i, m);
      end
      col = whole_part(px + w * (one / 2));
      row = whole_part(h * (one / 2) - py);
      p.on_screen = (col >= 0) && (col < w) && (row >= 0) && (row < h - 1);
      p.addr = p.on_screen ? ADDR_W'(row * (w + 1) + col) : '0;
      p.last = (i == m);
      expected_pixels.push_back(p);
    end
  endfunction

  function automatic void note_fault(string what, pixel_step_t exp_p, pixel_step_t got_p);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t %s: expected addr=%0d inside=%0b last=%0b, got addr=%0d inside=%0b last=%0b",
               $realtime, what, exp_p.addr, exp_p.on_screen, exp_p.last,
               got_p.addr, got_p.on_screen, got_p.last);
  endfunction

  always @(posedge clk) begin : watch
    pixel_step_t got_p;
    pixel_step_t exp_p;
    if (rst) begin
      cols = CFG_W'(MAX_SCREEN);
      rows = CFG_W'(MAX_SCREEN);
      expected_pixels.delete();
    end else begin
      // register writes: saturate, unknown indexes dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  cols = clamp_cfg(cfg_data, 1);
          REG_SCREEN_HEIGHT: rows = clamp_cfg(cfg_data, 2);
          default: ;
        endcase
      end
      // result side first; a new line cannot produce a pixel on its accept edge
      if (out_valid && !out_stall) begin
        got_p = '{addr: pixel_address, on_screen: pixel_inside, last: run_last};
        if (expected_pixels.size() == 0) begin
          note_fault("unexpected pixel", '0, got_p);
        end else begin
          exp_p = expected_pixels.pop_front();
          if (got_p.addr !== exp_p.addr || got_p.on_screen !== exp_p.on_screen ||
              got_p.last !== exp_p.last)
            note_fault("pixel mismatch", exp_p, got_p);
        end
      end
      if (in_valid && !in_stall)
        plot_line(longint'(start_x), longint'(start_y), longint'(end_x), longint'(end_y));
    end
    pending_steps <= expected_pixels.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Regression top for the line plotter: clock, reset, config writes, line stimulus, receiver stalls, verdict.
module testbench
  import dlcp_pkg::*;
();

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 7;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AFTER   = 40;

  // indexes with no register behind them
  localparam logic [IDX_W-1:0] REG_UNUSED_A = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_UNUSED_B = IDX_W'(3);

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_TRAIN,
    RX_HEAVY
  } rx_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [CRD_W-1:0] start_x = '0;
  logic signed [CRD_W-1:0] start_y = '0;
  logic signed [CRD_W-1:0] end_x = '0;
  logic signed [CRD_W-1:0] end_y = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ADDR_W-1:0]       pixel_address;
  logic                    pixel_inside;
  logic                    run_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  int fail_count;
  int pending_steps;
  int lines_sent = 0;
  int cycle_count = 0;

  always #(CLK_HALF) clk = ~clk;

  dda_line_char_plotter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_address(pixel_address),
    .pixel_inside (pixel_inside),
    .run_last     (run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dda_line_char_plotter_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_address(pixel_address),
    .pixel_inside (pixel_inside),
    .run_last     (run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_steps(pending_steps)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dda_line_char_plotter_unit regression: fail");
      $finish;
    end
  end

  // receiver: changing stall modes, with one long hold-off once HOLD_AFTER lines are sent
  initial begin : rx_stall
    rx_mode_t mode;
    int       span_left;
    int       hold_left;
    int       train_pos;
    bit       held;
    mode = RX_FREE;
    span_left = 0;
    hold_left = 0;
    train_pos = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && lines_sent >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (span_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span_left = $urandom_range(16, 96);
        end
        span_left--;
        train_pos = (train_pos + 1) % 4;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_COIN:  out_stall <= 1'($urandom_range(0, 1));
          RX_TRAIN: out_stall <= (train_pos != 0);
          default:  out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // holds valid high on return; caller lowers it
  task automatic offer_line(input int sx, input int sy, input int ex, input int ey);
    in_valid <= 1'b1;
    start_x <= CRD_W'(sx);
    start_y <= CRD_W'(sy);
    end_x <= CRD_W'(ex);
    end_y <= CRD_W'(ey);
    do @(posedge clk); while (in_stall);
    lines_sent++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_screen(input int w, input int h, input bit poke_unused);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    if (poke_unused) begin
      write_reg(REG_UNUSED_A, 127);
      write_reg(REG_UNUSED_B, 127);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_steps != 0);
  endtask

  // random lines in bursts; mostly full-range, some short, some zero-length
  task automatic feed_random(input int count);
    logic [CRD_W-1:0] sx, sy, ex, ey;
    int burst;
    int gap;
    burst = $urandom_range(1, 20);
    for (int k = 0; k < count; k++) begin
      sx = CRD_W'($urandom_range(0, 63));
      sy = CRD_W'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
        0: begin
          ex = sx;
          ey = sy;
        end
        1, 2, 3: begin
          ex = sx + CRD_W'($urandom_range(0, 6)) - CRD_W'(3);
          ey = sy + CRD_W'($urandom_range(0, 6)) - CRD_W'(3);
        end
        default: begin
          ex = CRD_W'($urandom_range(0, 63));
          ey = CRD_W'($urandom_range(0, 63));
        end
      endcase
      offer_line(int'(sx), int'(sy), int'(ex), int'(ey));
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst = $urandom_range(1, 20);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default 64x64: diagonals corner to corner, axis lines, zero length, steep and shallow
    offer_line(-32, -32, 31, 31);
    offer_line(31, 31, -32, -32);
    offer_line(-32, 31, 31, -32);
    offer_line(0, 0, 0, 0);
    offer_line(-32, -32, -32, -32);
    offer_line(31, 31, 31, 31);
    offer_line(-32, 0, 31, 0);
    offer_line(0, -32, 0, 31);
    offer_line(0, 0, 5, 31);
    offer_line(0, 0, 31, -5);
    offer_line(-1, 0, -3, 1);
    offer_line(5, 3, -7, 10);
    offer_line(0, -30, 2, -32);
    offer_line(-31, 30, 30, 29);
    in_valid <= 1'b0;
    wait_drained();

    // below range saturates to 1x2; unknown indexes must leave it alone
    set_screen(0, 0, 1'b1);
    offer_line(0, 1, -1, 1);
    offer_line(-1, 1, 0, 2);
    offer_line(0, 0, 0, 0);
    offer_line(-32, 31, 31, -32);
    in_valid <= 1'b0;
    wait_drained();

    // above range saturates to 64x64; long hold-off lands in here
    set_screen(127, 127, 1'b0);
    feed_random(60);
    wait_drained();

    set_screen(17, 9, 1'b0);
    feed_random(50);
    wait_drained();

    set_screen(64, 2, 1'b0);
    feed_random(30);
    wait_drained();

    set_screen(1, 64, 1'b0);
    feed_random(30);
    wait_drained();

    set_screen($urandom_range(0, 127), $urandom_range(0, 127), 1'b0);
    feed_random(60);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("dda_line_char_plotter_unit regression: pass");
    else
      $display("dda_line_char_plotter_unit regression: fail");
    $finish;
  end

endmodule
